FILE: src/ssoc_pkg.sv
// Shared types and constants for the sonar smoother / obstacle check unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package ssoc_pkg;

    // field widths
    localparam int COUNT_W   = 16;
    localparam int SCALED_W  = COUNT_W + 1;   // doubled count, no wrap
    localparam int CM_W      = SCALED_W;      // distance before 12-bit trim
    localparam int DIST_W    = 12;
    localparam int CHAN_W    = 2;
    localparam int MOTION_W  = 2;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // reciprocal multiply widths: magic constant needs one bit over the dividend
    localparam int MAGIC_W   = SCALED_W + 1;
    localparam int PROD_W    = SCALED_W + MAGIC_W;
    localparam int SQ_MAG_W  = DIST_W + 1;
    localparam int SQ_PROD_W = DIST_W + SQ_MAG_W;

    // parameter defaults
    localparam int SMOOTH_DEPTH_DEF  = 3;
    localparam int PULSE_DIVISOR_DEF = 58;
    localparam int NUM_CH            = 3;

    // channel codes
    localparam logic [CHAN_W-1:0] CH_FRONT  = 2'd0;
    localparam logic [CHAN_W-1:0] CH_RIGHT  = 2'd1;
    localparam logic [CHAN_W-1:0] CH_LEFT   = 2'd2;
    localparam logic [CHAN_W-1:0] CH_UNUSED = 2'd3;

    // motion codes
    localparam logic [MOTION_W-1:0] MOT_STILL = 2'd0;
    localparam logic [MOTION_W-1:0] MOT_LEFT  = 2'd1;
    localparam logic [MOTION_W-1:0] MOT_RIGHT = 2'd2;
    localparam logic [MOTION_W-1:0] MOT_FWD   = 2'd3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NONE        = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EVADE_RIGHT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVADE_LEFT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP        = 2'd3;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LIMIT = 2'd1;
    localparam logic [DIST_W-1:0]    SIDE_LIMIT_RST  = 12'd24;
    localparam logic [DIST_W-1:0]    FRONT_LIMIT_RST = 12'd20;

    // capture after the input register: distance and its share of the average
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [MOTION_W-1:0] motion;
        logic [CM_W-1:0]     cm;
        logic [DIST_W-1:0]   new_q;
    } ssoc_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] side;
        logic [DIST_W-1:0] front;
    } ssoc_limits_t;

endpackage
`default_nettype wire

FILE: src/ssoc_in_stage.sv
// Input register: converts the pulse count to centimetres and to the
// per-capture share of the average. Depends on ssoc_pkg.
`default_nettype none
module ssoc_in_stage #(
    parameter int PULSE_DIVISOR = 58,
    parameter int SMOOTH_DEPTH  = 3
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ssoc_pkg::CHAN_W-1:0]     in_channel,
    input  wire logic [ssoc_pkg::COUNT_W-1:0]    in_count,
    input  wire logic [ssoc_pkg::MOTION_W-1:0]   in_motion,
    output logic                                 item_valid,
    output ssoc_pkg::ssoc_item_t                 item,
    input  wire logic                            item_take
);
    import ssoc_pkg::*;

    // floor(x/d) = (x * ceil(2^(N+l)/d)) >> (N+l), exact for any N-bit x
    localparam int          CmShift  = SCALED_W + $clog2(PULSE_DIVISOR);
    localparam logic [63:0] CmMagic  = ((64'd1 << CmShift) + 64'(PULSE_DIVISOR) - 64'd1)
                                       / 64'(PULSE_DIVISOR);
    localparam int          QDiv     = PULSE_DIVISOR * SMOOTH_DEPTH;
    localparam int          QShift   = SCALED_W + $clog2(QDiv);
    localparam logic [63:0] QMagic   = ((64'd1 << QShift) + 64'(QDiv) - 64'd1) / 64'(QDiv);

    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   cm_prod;
    logic [PROD_W-1:0]   q_prod;
    logic                vld_reg;
    ssoc_item_t          item_reg;
    ssoc_item_t          item_next;
    logic                accept;

    assign scaled  = {in_count, 1'b0};
    assign cm_prod = PROD_W'(scaled) * PROD_W'(CmMagic[MAGIC_W-1:0]);
    // floor(floor(x/d)/n) == floor(x/(d*n))
    assign q_prod  = PROD_W'(scaled) * PROD_W'(QMagic[MAGIC_W-1:0]);

    always_comb begin
        item_next.channel = in_channel;
        item_next.motion  = in_motion;
        item_next.cm      = CM_W'(cm_prod >> CmShift);
        item_next.new_q   = DIST_W'(q_prod >> QShift);
    end

    assign in_ready   = !vld_reg || item_take;
    assign accept     = in_valid && in_ready;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (accept) begin
            // unused channel code is dropped here: no state change, no result
            vld_reg <= (in_channel != CH_UNUSED);
        end else if (item_take) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/ssoc_smooth_core.sv
// Per-channel history lines, running averages, obstacle decision and result
// register. Depends on ssoc_pkg.
`default_nettype none
module ssoc_smooth_core #(
    parameter int SMOOTH_DEPTH = 3
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            item_valid,
    input  wire ssoc_pkg::ssoc_item_t            item,
    output logic                                 item_take,
    input  wire ssoc_pkg::ssoc_limits_t          limits,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic [ssoc_pkg::CHAN_W-1:0]          res_channel,
    output logic [ssoc_pkg::DIST_W-1:0]          res_smoothed,
    output logic [ssoc_pkg::ACTION_W-1:0]        res_action
);
    import ssoc_pkg::*;

    localparam int          SqShift = DIST_W + $clog2(SMOOTH_DEPTH);
    localparam logic [63:0] SqMagic = ((64'd1 << SqShift) + 64'(SMOOTH_DEPTH) - 64'd1)
                                      / 64'(SMOOTH_DEPTH);

    // each line holds the stored distances already divided by the depth;
    // the oldest sits at the far tap
    logic [DIST_W-1:0] line_reg [NUM_CH][SMOOTH_DEPTH];
    logic [DIST_W-1:0] avg_reg  [NUM_CH];
    logic [DIST_W-1:0] avg_view [NUM_CH];

    logic [SQ_PROD_W-1:0] sq_prod;
    logic [DIST_W-1:0]    stored_q;
    logic [DIST_W-1:0]    old_q;
    logic [DIST_W-1:0]    avg_new;
    logic [ACTION_W-1:0]  action;

    logic                 vld_reg;
    logic [CHAN_W-1:0]    ch_reg;
    logic [DIST_W-1:0]    smooth_reg;
    logic [ACTION_W-1:0]  act_reg;

    assign item_take = item_valid && (!vld_reg || res_ready);

    // history keeps the distance trimmed to 12 bits
    assign sq_prod  = SQ_PROD_W'(item.cm[DIST_W-1:0]) * SQ_PROD_W'(SqMagic[SQ_MAG_W-1:0]);
    assign stored_q = DIST_W'(sq_prod >> SqShift);
    assign old_q    = line_reg[item.channel][SMOOTH_DEPTH-1];
    assign avg_new  = avg_reg[item.channel] - old_q + item.new_q;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            avg_view[c] = (CHAN_W'(c) == item.channel) ? avg_new : avg_reg[c];
        end
    end

    always_comb begin
        unique case (item.motion)
            MOT_STILL: action = ACT_NONE;
            MOT_LEFT:  action = (avg_view[CH_RIGHT] <= limits.side) ? ACT_EVADE_RIGHT
                                                                    : ACT_NONE;
            MOT_RIGHT: action = (avg_view[CH_LEFT] <= limits.side) ? ACT_EVADE_LEFT
                                                                   : ACT_NONE;
            MOT_FWD:   action = (avg_view[CH_FRONT] <= limits.front) ? ACT_STOP
                                                                     : ACT_NONE;
            default:   action = ACT_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                avg_reg[c] <= '0;
                for (int k = 0; k < SMOOTH_DEPTH; k++) begin
                    line_reg[c][k] <= '0;
                end
            end
        end else if (item_take) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (CHAN_W'(c) == item.channel) begin
                    avg_reg[c]     <= avg_new;
                    line_reg[c][0] <= stored_q;
                    for (int k = 1; k < SMOOTH_DEPTH; k++) begin
                        line_reg[c][k] <= line_reg[c][k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (item_take) begin
            vld_reg <= 1'b1;
        end else if (res_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            ch_reg     <= item.channel;
            smooth_reg <= avg_new;
            act_reg    <= action;
        end
    end

    assign res_valid    = vld_reg;
    assign res_channel  = ch_reg;
    assign res_smoothed = smooth_reg;
    assign res_action   = act_reg;

endmodule
`default_nettype wire

FILE: src/sonar_smoother_obstacle_check_unit.sv
// m_tvalid rises once an input transaction has passed the input register, then the
// result register; one capture accepted per cycle while m_tready does not hold a result,
// set by the single average-update stage.
// Captures on the unused channel code give no result.
// Reset (aresetn low, synchronous) zeroes all averages and histories and
// loads the side and front limits with 24 and 20 cm.
// Depends on ssoc_pkg, ssoc_in_stage and ssoc_smooth_core.
`default_nettype none
module sonar_smoother_obstacle_check_unit #(
    parameter int SMOOTH_DEPTH  = ssoc_pkg::SMOOTH_DEPTH_DEF,
    parameter int PULSE_DIVISOR = ssoc_pkg::PULSE_DIVISOR_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // capture stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [ssoc_pkg::S_TDATA_W-1:0]     s_tdata,  // [15:0] pulse_count, [17:16] motion
    input  wire logic [ssoc_pkg::CHAN_W-1:0]        s_tuser,  // [1:0] sensor_channel
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [ssoc_pkg::M_TDATA_W-1:0]          m_tdata,  // [11:0] smoothed_cm, [13:12] evade_action
    output logic [ssoc_pkg::CHAN_W-1:0]             m_tuser,  // [1:0] result_channel
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ssoc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [ssoc_pkg::DIST_W-1:0]        cfg_wdata
);
    import ssoc_pkg::*;

    ssoc_limits_t        limits_reg;
    ssoc_item_t          item;
    logic                item_valid;
    logic                item_take;
    logic [DIST_W-1:0]   res_smoothed;
    logic [ACTION_W-1:0] res_action;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.side  <= SIDE_LIMIT_RST;
            limits_reg.front <= FRONT_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_SIDE_LIMIT:  limits_reg.side  <= cfg_wdata;
                CFG_FRONT_LIMIT: limits_reg.front <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ssoc_in_stage #(
        .PULSE_DIVISOR (PULSE_DIVISOR),
        .SMOOTH_DEPTH  (SMOOTH_DEPTH)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_channel (s_tuser),
        .in_count   (s_tdata[COUNT_W-1:0]),
        .in_motion  (s_tdata[COUNT_W +: MOTION_W]),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ssoc_smooth_core #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH)
    ) u_smooth_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .limits       (limits_reg),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_channel  (m_tuser),
        .res_smoothed (res_smoothed),
        .res_action   (res_action)
    );

    assign m_tdata = {{(M_TDATA_W - DIST_W - ACTION_W){1'b0}}, res_action, res_smoothed};

endmodule
`default_nettype wire
